// File: design/ist_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table package
// Shared constants, command codes, beat types and the slot priority encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W     = 3;
    localparam int CMD_W      = 2;
    localparam int IP_W       = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DEFAULT = 2'd3;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_DEFAULT_SLOT = 3'd0;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IP_W-1:0]  address;
        logic [IP_W-1:0]  netmask;
        logic [IP_W-1:0]  gateway;
    } req_t;

    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   entry_address;
        logic [IP_W-1:0]   entry_netmask;
        logic [IP_W-1:0]   entry_gateway;
    } result_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [SLOT_IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] vec);
        logic [SLOT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = SLOT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: design/ist_cfg_regs.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table configuration registers
// APB-style register file holding the default slot index.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_cfg_regs
    import ist_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [SLOT_W-1:0]  default_slot
);

    logic [SLOT_W-1:0] default_slot_reg;
    logic [SLOT_W-1:0] default_slot_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_DEFAULT_SLOT);

    always_comb
    begin
        default_slot_next = default_slot_reg;
        if (wr_en)
        begin
            default_slot_next = pwdata[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_slot_reg <= '0;
        end
        else
        begin
            default_slot_reg <= default_slot_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_DEFAULT_SLOT)
        begin
            prdata = PDATA_W'(default_slot_reg);
        end
    end

    assign default_slot = default_slot_reg;

endmodule

`default_nettype wire

// File: design/ist_slot_table.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table storage and command logic
// Holds the entries and valid bits, matches all slots in parallel and forms
// the result of one command per cycle; state changes only when fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_slot_table
    import ist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire req_t              req,
    input  wire logic [SLOT_W-1:0] default_slot,
    output result_t                result
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [IP_W-1:0]  address_store_reg [SLOTS];
    logic [IP_W-1:0]  netmask_store_reg [SLOTS];
    logic [IP_W-1:0]  gateway_store_reg [SLOTS];

    logic [SLOTS-1:0]      match_vec;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [SLOT_IDX_W-1:0] dflt_idx;
    logic                  table_full;
    logic                  table_empty;
    logic                  dflt_in_range;
    logic                  alloc_ok;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i] && (address_store_reg[i] == req.address);
        end
    end

    assign free_idx      = lowest_set(~valid_reg);
    assign match_idx     = lowest_set(match_vec);
    assign dflt_idx      = default_slot[SLOT_IDX_W-1:0];
    assign table_full    = &valid_reg;
    assign table_empty   = ~|valid_reg;
    assign dflt_in_range = 32'(default_slot) < 32'(SLOTS);
    assign alloc_ok      = fire && (req.command == CMD_ALLOC) && !table_full;

    always_comb
    begin
        result     = '0;
        valid_next = valid_reg;
        case (req.command)
            CMD_ALLOC:
            begin
                if (!table_full)
                begin
                    result.success       = 1'b1;
                    result.slot          = SLOT_W'(free_idx);
                    result.entry_address = req.address;
                    result.entry_netmask = req.netmask;
                    result.entry_gateway = req.gateway;
                    valid_next[free_idx] = 1'b1;
                end
            end
            CMD_DEFAULT:
            begin
                if (!table_empty && dflt_in_range)
                begin
                    result.success       = 1'b1;
                    result.slot          = SLOT_W'(dflt_idx);
                    result.entry_address = address_store_reg[dflt_idx];
                    result.entry_netmask = netmask_store_reg[dflt_idx];
                    result.entry_gateway = gateway_store_reg[dflt_idx];
                end
            end
            CMD_FREE, CMD_LOOKUP:
            begin
                if (|match_vec)
                begin
                    result.success       = 1'b1;
                    result.slot          = SLOT_W'(match_idx);
                    result.entry_address = address_store_reg[match_idx];
                    result.entry_netmask = netmask_store_reg[match_idx];
                    result.entry_gateway = gateway_store_reg[match_idx];
                    if (req.command == CMD_FREE)
                    begin
                        valid_next[match_idx] = 1'b0;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
        end
    end

    // A slot that was never allocated must still read back as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                address_store_reg[i] <= '0;
                netmask_store_reg[i] <= '0;
                gateway_store_reg[i] <= '0;
            end
        end
        else if (alloc_ok)
        begin
            address_store_reg[free_idx] <= req.address;
            netmask_store_reg[free_idx] <= req.netmask;
            gateway_store_reg[free_idx] <= req.gateway;
        end
    end

    a_alloc_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.command == CMD_ALLOC) && result.success
        |=> $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("allocate did not mark exactly one new slot");

    a_free_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.command == CMD_FREE) && result.success
        |=> $countones(valid_reg) + 1 == $countones($past(valid_reg)))
        else $error("free did not release exactly one slot");

    a_read_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ((req.command == CMD_LOOKUP) || (req.command == CMD_DEFAULT))
        |=> valid_reg == $past(valid_reg))
        else $error("lookup or get-default changed the valid bits");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.success |-> (result.slot == '0) && (result.entry_address == '0)
        && (result.entry_netmask == '0) && (result.entry_gateway == '0))
        else $error("failed command carries nonzero entry fields");

endmodule

`default_nettype wire

// File: design/ipv4_interface_slot_table.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table
// Eight-entry table of interface address, netmask and gateway with allocate,
// free, lookup and get-default commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat enters on command/address/netmask/gateway under
//   cmd_valid/cmd_ready. Every command gives exactly one result beat on
//   success/slot/entry_* under result_valid/result_ready, in order.
//   A beat is registered in the input register on acceptance and is
//   processed once the result register can take it: all slots are
//   compared in parallel and priority encoded, and the result register
//   is loaded with the outcome, which raises result_valid. One command
//   is taken per cycle when the receiver keeps result_ready high.
//   When the receiver stalls, the result is held and one further command
//   waits in the input register; cmd_ready then drops until the result
//   beat is taken.
//   The default slot register is written over the APB-style port at
//   byte address 0. Reset clears the valid bits, the stored entries and the
//   default slot to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_interface_slot_table
    import ist_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [IP_W-1:0]    address,
    input  wire logic [IP_W-1:0]    netmask,
    input  wire logic [IP_W-1:0]    gateway,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic                    success,
    output logic      [SLOT_W-1:0]  slot,
    output logic      [IP_W-1:0]    entry_address,
    output logic      [IP_W-1:0]    entry_netmask,
    output logic      [IP_W-1:0]    entry_gateway
);

    logic              req_valid_reg;
    logic              req_valid_next;
    req_t              req_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           res_reg;
    result_t           res_comb;
    logic [SLOT_W-1:0] default_slot;
    logic              fire;
    logic              take_cmd;

    ist_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_slot (default_slot)
    );

    ist_slot_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .req          (req_reg),
        .default_slot (default_slot),
        .result       (res_comb)
    );

    // The held command executes only when the result register can take it.
    assign fire      = req_valid_reg && (!res_valid_reg || result_ready);
    assign cmd_ready = !req_valid_reg || fire;
    assign take_cmd  = cmd_valid && cmd_ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (take_cmd)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            req_reg.command <= command;
            req_reg.address <= address;
            req_reg.netmask <= netmask;
            req_reg.gateway <= gateway;
        end
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign result_valid  = res_valid_reg;
    assign success       = res_reg.success;
    assign slot          = res_reg.slot;
    assign entry_address = res_reg.entry_address;
    assign entry_netmask = res_reg.entry_netmask;
    assign entry_gateway = res_reg.entry_gateway;

endmodule

`default_nettype wire

// File: verif/ist_checker.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table checker
// Watches the command, result and register ports, keeps its own copy of the
// slot table and compares every result beat with the predicted entry.
// ----------------------------------------------------------------------------
module ist_checker
    import ist_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_ready,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [IP_W-1:0]    address,
    input  wire logic [IP_W-1:0]    netmask,
    input  wire logic [IP_W-1:0]    gateway,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire logic               success,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [IP_W-1:0]    entry_address,
    input  wire logic [IP_W-1:0]    entry_netmask,
    input  wire logic [IP_W-1:0]    entry_gateway,
    output int                      outstanding,
    output int                      failures
);

    logic [SLOT_W-1:0] default_slot_copy;
    logic [SLOTS-1:0]  slot_in_use;
    logic [IP_W-1:0]   address_tab [SLOTS];
    logic [IP_W-1:0]   netmask_tab [SLOTS];
    logic [IP_W-1:0]   gateway_tab [SLOTS];
    result_t           results_due [$];
    result_t           want;
    req_t              cmd_beat;
    int                error_count;

    function automatic result_t entry_of(int idx);
        result_t r;
        r.success       = 1'b1;
        r.slot          = SLOT_W'(idx);
        r.entry_address = address_tab[idx];
        r.entry_netmask = netmask_tab[idx];
        r.entry_gateway = gateway_tab[idx];
        return r;
    endfunction

    // Applies one command to the table copy and returns the result it gives.
    function automatic result_t execute_command(req_t c);
        result_t r;
        int      hit;
        int      i;
        r   = '0;
        hit = -1;
        if (c.command == CMD_ALLOC)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (!slot_in_use[i] && hit < 0)
                begin
                    hit = i;
                end
            end
            if (hit >= 0)
            begin
                slot_in_use[hit] = 1'b1;
                address_tab[hit] = c.address;
                netmask_tab[hit] = c.netmask;
                gateway_tab[hit] = c.gateway;
                r = entry_of(hit);
            end
        end
        else if (slot_in_use != '0)
        begin
            if (c.command == CMD_DEFAULT)
            begin
                // A default slot that is not in use still returns its stale contents.
                if (int'(default_slot_copy) < SLOTS)
                begin
                    r = entry_of(int'(default_slot_copy));
                end
            end
            else
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_in_use[i] && address_tab[i] == c.address && hit < 0)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    r = entry_of(hit);
                    // Freeing drops the valid bit only; the stored words stay.
                    if (c.command == CMD_FREE)
                    begin
                        slot_in_use[hit] = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [IP_W-1:0] exp_val,
                                        logic [IP_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_slot_copy = '0;
            slot_in_use       = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                address_tab[i] = '0;
                netmask_tab[i] = '0;
                gateway_tab[i] = '0;
            end
            results_due.delete();
            error_count = 0;
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %b %h %h %h %h",
                             $time, success, slot, entry_address, entry_netmask,
                             entry_gateway);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("success", IP_W'(want.success), IP_W'(success));
                    check_field("slot", IP_W'(want.slot), IP_W'(slot));
                    check_field("entry_address", want.entry_address, entry_address);
                    check_field("entry_netmask", want.entry_netmask, entry_netmask);
                    check_field("entry_gateway", want.entry_gateway, entry_gateway);
                end
            end
            if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_SLOT)
            begin
                default_slot_copy = pwdata[SLOT_W-1:0];
            end
            if (cmd_valid && cmd_ready)
            begin
                cmd_beat.command = command;
                cmd_beat.address = address;
                cmd_beat.netmask = netmask;
                cmd_beat.gateway = gateway;
                results_due.push_back(execute_command(cmd_beat));
            end
            outstanding <= results_due.size();
            failures    <= error_count;
        end
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// IPv4 interface slot table testbench
// Drives directed and random table commands with bursty traffic, a stalling
// receiver and several default slot settings; the checker judges each beat.
// ----------------------------------------------------------------------------
module tb_top;
    import ist_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 280;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               cmd_valid     = 1'b0;
    logic               cmd_ready;
    logic [CMD_W-1:0]   command       = CMD_ALLOC;
    logic [IP_W-1:0]    address       = '0;
    logic [IP_W-1:0]    netmask       = '0;
    logic [IP_W-1:0]    gateway       = '0;
    logic               result_valid;
    logic               result_ready  = 1'b0;
    logic               success;
    logic [SLOT_W-1:0]  slot;
    logic [IP_W-1:0]    entry_address;
    logic [IP_W-1:0]    entry_netmask;
    logic [IP_W-1:0]    entry_gateway;
    int                 outstanding;
    int                 failures;
    int                 quiet_cycles  = 0;
    logic [IP_W-1:0]    addr_pool [8];

    ipv4_interface_slot_table uut (.*);

    ist_checker checker_i (.*);

    always #5 clk = ~clk;

    // Runs the whole time: nothing accepted for too long means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (result_valid && result_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: stretches of steady, random or sparse ready, with a long
    // hold-off now and then so that the block backs up into the sender.
    initial
    begin
        int stretch;
        int pct;
        stretch = 0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stretch++;
            if (stretch % 12 == 4)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(60, 90)) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       pct = 100;
                    1:       pct = 75;
                    2:       pct = 50;
                    default: pct = 20;
                endcase
                repeat ($urandom_range(10, 50))
                begin
                    result_ready <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                end
            end
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one command beat and returns at the edge where it is taken.
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] a,
                                input logic [IP_W-1:0] m, input logic [IP_W-1:0] g);
        command   <= c;
        address   <= a;
        netmask   <= m;
        gateway   <= g;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Holds the sender until every result beat has been taken.
    task automatic drain_table_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic refresh_addr_pool();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 8; i++)
        begin
            addr_pool[i] = $urandom;
        end
    endtask

    // Filling favors allocate, draining favors free, so the table keeps
    // swinging between empty and full.
    task automatic send_table_command(input logic filling);
        int               roll;
        logic [CMD_W-1:0] c;
        logic [IP_W-1:0]  a;
        logic [IP_W-1:0]  m;
        roll = $urandom_range(0, 99);
        if (filling)
        begin
            c = (roll < 50) ? CMD_ALLOC : (roll < 65) ? CMD_FREE :
                (roll < 85) ? CMD_LOOKUP : CMD_DEFAULT;
        end
        else
        begin
            c = (roll < 15) ? CMD_ALLOC : (roll < 60) ? CMD_FREE :
                (roll < 85) ? CMD_LOOKUP : CMD_DEFAULT;
        end
        a = ($urandom_range(0, 99) < 80) ? addr_pool[$urandom_range(0, 7)] : $urandom;
        if ($urandom_range(0, 2) == 0)
        begin
            m = $urandom;
        end
        else
        begin
            m = 32'hffff_ffff << (32 - $urandom_range(0, 32));
        end
        send_command(c, a, m, $urandom);
    endtask

    task automatic run_directed();
        send_command(CMD_DEFAULT, $urandom, $urandom, $urandom);
        send_command(CMD_LOOKUP, 32'h0, $urandom, $urandom);
        send_command(CMD_FREE, 32'h0, $urandom, $urandom);
        send_command(CMD_ALLOC, 32'h0, 32'h0, 32'h0);
        send_command(CMD_ALLOC, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_ALLOC, 32'hc0a8_0001, 32'hffff_ff00, 32'hc0a8_00fe);
        // Same address twice: free and lookup must pick the lower slot.
        send_command(CMD_ALLOC, 32'hc0a8_0001, 32'hffff_0000, 32'h0a00_0001);
        repeat (4) send_command(CMD_ALLOC, $urandom, $urandom, $urandom);
        send_command(CMD_ALLOC, 32'h0a0a_0a0a, 32'hff00_0000, 32'h0a00_0001);
        send_command(CMD_LOOKUP, 32'hc0a8_0001, $urandom, $urandom);
        send_command(CMD_FREE, 32'hc0a8_0001, $urandom, $urandom);
        send_command(CMD_LOOKUP, 32'hc0a8_0001, $urandom, $urandom);
        send_command(CMD_FREE, 32'h0, $urandom, $urandom);
        // Default slot 0 is now free but still holds its old entry.
        send_command(CMD_DEFAULT, $urandom, $urandom, $urandom);
        send_command(CMD_LOOKUP, 32'h0, $urandom, $urandom);
        send_command(CMD_FREE, 32'h1234_5678, $urandom, $urandom);
        send_command(CMD_ALLOC, 32'h0a00_0002, 32'hffff_fffc, 32'h0a00_0001);
        send_command(CMD_LOOKUP, 32'hffff_ffff, $urandom, $urandom);
    endtask

    initial
    begin
        int   slot_plan [6];
        int   burst_left;
        logic filling;
        slot_plan  = '{7, 0, 3, 5, 1, 6};
        burst_left = 0;
        filling    = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < 6; p++)
        begin
            drain_table_results();
            apb_write(REG_DEFAULT_SLOT,
                      (p == 4) ? PDATA_W'($urandom_range(0, SLOTS - 1)) : PDATA_W'(slot_plan[p]));
            refresh_addr_pool();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 35 == 0)
                begin
                    filling = ~filling;
                end
                if (burst_left == 0)
                begin
                    idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 30);
                end
                send_table_command(filling);
                burst_left--;
            end
        end

        drain_table_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
